[rtl/core/hrtt_pkg.sv]
// Shared types and constants of the request tracking table.
package hrtt_pkg;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int unsigned BUCKET_W = 8;
  localparam int unsigned BUCKETS  = 1 << BUCKET_W;

  // Entry payload without the key
  typedef struct packed {
    logic [7:0]         flags;
    logic signed [31:0] tag;
    logic signed [31:0] dest;
    logic [30:0]        bytes;
    logic [31:0]        datatype;
    logic [31:0]        comm;
    logic [31:0]        id;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Command word from front to back
  typedef struct packed {
    logic [1:0]          func;
    logic [31:0]         handle;
    logic [BUCKET_W-1:0] bucket;
    entry_t              data;
  } cmd_t;

  // Bucket hash: XOR of lowest and highest byte
  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [31:0] h);
    bucket_of = h[7:0] ^ h[31:24];
  endfunction

endpackage

[rtl/core/hashed_request_tracking_table_top.sv]
// Top level of the hashed request tracking table.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request word: func,
//   handle and the data stored on insert. Output channel (out_valid_o /
//   out_stall_i) carries one result word per request: status and found_*.
//   A word moves at a clock edge with valid high and stall low.
//   The handle picks one of 256 buckets (low byte XOR high byte).
//   Front end hashes and queues up to two words; back end runs one at a time
//   and starts the next word the cycle after the previous result is taken.
//   Insert writes the new entry without a scan; lookup and remove scan the
//   bucket's entries until a hit or the end; a remove hit then copies the
//   last entry over the hit slot. The scan reads one slot a cycle through
//   the one entry RAM read port.
//   After reset the back end clears all 256 bucket counts in the count
//   RAM; up to two words queue meanwhile, then in_stall_o rises.
//   While the receiver stalls the result holds; the back end then waits and
//   the input queue fills, after which in_stall_o rises.
module hashed_request_tracking_table_top #(
  parameter int unsigned SLOTS_PER_BUCKET = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        handle_i,
  input  logic [7:0]         req_flags_i,
  input  logic signed [31:0] req_tag_i,
  input  logic signed [31:0] req_dest_i,
  input  logic [30:0]        req_bytes_i,
  input  logic [31:0]        req_datatype_i,
  input  logic [31:0]        req_comm_i,
  input  logic [31:0]        req_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         found_flags_o,
  output logic signed [31:0] found_tag_o,
  output logic signed [31:0] found_dest_o,
  output logic [30:0]        found_bytes_o,
  output logic [31:0]        found_datatype_o,
  output logic [31:0]        found_comm_o,
  output logic [31:0]        found_id_o
);

  hrtt_pkg::cmd_t   in_cmd, q_cmd;
  hrtt_pkg::entry_t found;
  logic             q_valid, q_pop;

  // Pack the request word
  always_comb begin
    in_cmd               = '0;
    in_cmd.func          = func_i;
    in_cmd.handle        = handle_i;
    in_cmd.data.flags    = req_flags_i;
    in_cmd.data.tag      = req_tag_i;
    in_cmd.data.dest     = req_dest_i;
    in_cmd.data.bytes    = req_bytes_i;
    in_cmd.data.datatype = req_datatype_i;
    in_cmd.data.comm     = req_comm_i;
    in_cmd.data.id       = req_id_i;
  end

  hrtt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (in_cmd),
    .cmd_valid_o(q_valid),
    .cmd_pop_i  (q_pop),
    .cmd_o      (q_cmd)
  );

  hrtt_back #(.SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_pop_o  (q_pop),
    .cmd_i      (q_cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .found_o    (found)
  );

  assign found_flags_o    = found.flags;
  assign found_tag_o      = found.tag;
  assign found_dest_o     = found.dest;
  assign found_bytes_o    = found.bytes;
  assign found_datatype_o = found.datatype;
  assign found_comm_o     = found.comm;
  assign found_id_o       = found.id;

endmodule

[rtl/core/hrtt_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
module hrtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/hrtt_front.sv]
// Front end: accepts words, hashes the handle and feeds a two-entry queue.
module hrtt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hrtt_pkg::cmd_t    cmd_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output hrtt_pkg::cmd_t    cmd_o
);

  hrtt_pkg::cmd_t entry_q [2];
  hrtt_pkg::cmd_t push_cmd;
  logic [1:0]     cnt_q;
  logic           rd_q, wr_q;
  logic           push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cnt_q != 2'd0;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_q];

  // Incoming word with its bucket filled in
  always_comb begin
    push_cmd        = cmd_i;
    push_cmd.bucket = hrtt_pkg::bucket_of(cmd_i.handle);
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_cmd;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/hrtt_back.sv]
// Back end: bucket scan, insert, swap-remove and result register.
module hrtt_back #(
  parameter int unsigned SLOTS_PER_BUCKET = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  hrtt_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output hrtt_pkg::entry_t found_o
);

  localparam int unsigned SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned CW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned AW = hrtt_pkg::BUCKET_W + SW;
  localparam int unsigned DEPTH = hrtt_pkg::BUCKETS << SW;
  localparam int unsigned RW = 32 + hrtt_pkg::ENTRY_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;
  localparam logic [2:0] S_CNT  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [hrtt_pkg::BUCKET_W-1:0] clr_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] slot_q;
  logic [SW-1:0] hit_q;
  hrtt_pkg::cmd_t cur_q;
  hrtt_pkg::entry_t hold_q;
  logic [1:0]    status_q;
  logic          out_valid_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [SW-1:0] rslot;
  logic          ins_ok, key_hit;

  logic                          cnt_we;
  logic [hrtt_pkg::BUCKET_W-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0]                 cnt_wdata, cnt_rdata;

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = hold_q;

  assign ins_ok  = (state_q == S_READ) && cur_q.func == hrtt_pkg::FUNC_INSERT &&
                   n_q != CW'(SLOTS_PER_BUCKET);
  assign key_hit = (state_q == S_CMP) && rdata[RW-1 -: 32] == cur_q.handle;

  hrtt_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  hrtt_ram #(.WIDTH(CW), .DEPTH(hrtt_pkg::BUCKETS)) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rdata)
  );

  // Bucket counts: cleared after reset, read at pop, updated on insert/remove
  always_comb begin
    cnt_raddr = (state_q == S_IDLE) ? cmd_i.bucket : cur_q.bucket;
    cnt_we    = 1'b0;
    cnt_waddr = cur_q.bucket;
    cnt_wdata = '0;
    if (state_q == S_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
    end else if (ins_ok) begin
      cnt_we    = 1'b1;
      cnt_wdata = n_q + CW'(1);
    end else if (key_hit && cur_q.func == hrtt_pkg::FUNC_REMOVE) begin
      cnt_we    = 1'b1;
      cnt_wdata = n_q - CW'(1);
    end
  end

  // Read address: scan slot, or last slot while preparing a move
  always_comb begin
    rslot = (state_q == S_LAST) ? SW'(n_q - CW'(1)) : slot_q[SW-1:0];
    raddr = {cur_q.bucket, rslot};
  end

  // Write port: insert appends, remove copies last over hit
  always_comb begin
    we    = 1'b0;
    waddr = {cur_q.bucket, slot_q[SW-1:0]};
    wdata = {cur_q.handle, cur_q.data};
    if (ins_ok) begin
      we    = 1'b1;
      waddr = {cur_q.bucket, n_q[SW-1:0]};
    end else if (state_q == S_MOVE) begin
      we    = 1'b1;
      waddr = {cur_q.bucket, hit_q};
      wdata = rdata;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: if (cmd_pop_o) state_d = S_CNT;
      S_CNT:  state_d = S_READ;
      S_READ: begin
        if (cur_q.func == hrtt_pkg::FUNC_INSERT || cur_q.func == hrtt_pkg::FUNC_NONE ||
            slot_q == n_q) state_d = S_OUT;
        else state_d = S_CMP;
      end
      S_CMP: begin
        if (key_hit) begin
          if (cur_q.func == hrtt_pkg::FUNC_REMOVE) state_d = S_LAST;
          else state_d = S_OUT;
        end else if (slot_q == n_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_CMP;
        end
      end
      S_LAST: state_d = S_MOVE;
      S_MOVE: state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (state_q == S_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == S_IDLE) slot_q <= '0;
      else if (state_q == S_READ || state_q == S_CMP) slot_q <= slot_q + CW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (state_q == S_CNT) begin
      n_q <= cnt_rdata;
    end
    if (state_q == S_READ) begin
      hold_q <= '0;
      if (cur_q.func == hrtt_pkg::FUNC_INSERT)
        status_q <= (n_q == CW'(SLOTS_PER_BUCKET)) ? hrtt_pkg::ST_FULL : hrtt_pkg::ST_OK;
      else
        status_q <= hrtt_pkg::ST_NOT_FOUND;
    end
    if (key_hit) begin
      hold_q   <= rdata[hrtt_pkg::ENTRY_W-1:0];
      status_q <= hrtt_pkg::ST_OK;
      hit_q    <= SW'(slot_q - CW'(1));
    end
  end

endmodule

[rtl/core/hrtt_checker.sv]
// Port-level checker for the request tracking table, bound to the top level.
module hrtt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] found_id_o,
  input logic [7:0]  found_flags_o
);

  // Stalled result stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(found_id_o))
    else $error("stalled result changed");

  // Status is never the reserved code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= hrtt_pkg::ST_FULL)
    else $error("bad status");

  // No data reported on a failed request
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != hrtt_pkg::ST_OK |-> found_id_o == '0 && found_flags_o == '0)
    else $error("data on failed request");

endmodule

bind hashed_request_tracking_table_top hrtt_checker u_hrtt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .found_id_o   (found_id_o),
  .found_flags_o(found_flags_o)
);
